[design/rhh_pkg.sv]
// rhh_pkg: shared types, status codes and constants of the robin hood hash table
// depends on nothing; used by every module of the block
package rhh_pkg;

  localparam int unsigned TableSlotsDef = 1024;
  localparam int unsigned KeyWidthDef   = 32;
  localparam int unsigned KeyMaxW       = 64;
  localparam int unsigned HashW         = 31;
  localparam int unsigned LoadNum       = 8;
  localparam int unsigned LoadDen       = 10;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_PRESENT  = 3'd1,
    ST_FOUND    = 3'd2,
    ST_MISSING  = 3'd3,
    ST_FULL     = 3'd4
  } status_e;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_FIND   = 1'b1
  } op_e;

  typedef struct packed {
    logic        req_type;
    logic [31:0] key;
    logic [30:0] hash_value;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [9:0] slot_index;
  } rsp_t;

  // decoded request handed from front to back
  typedef struct packed {
    op_e                op;
    logic [KeyMaxW-1:0] key;
    logic [HashW-1:0]   hash;
  } cmd_t;

endpackage

[design/robin_hood_hash_table_core.sv]
// robin_hood_hash_table_core: top level of the robin hood hash table
// depends on rhh_pkg, rhh_front and rhh_back
//
// open-addressed hash table with robin hood linear probing. each request beat carries an
// insert or a find, a key and a caller-computed 31-bit hash; exactly one result beat comes
// back per request, in order. a front stage decodes requests into a two-entry queue, so up
// to two further requests are taken while one is being worked on and its result waits.
// the back sequencer probes one slot at a time, each probe a registered read of the slot
// memories, then compare and optional swap write; the probe count is the data-dependent
// run from the home slot. after reset a clearing pass empties the slot store, during which
// no request is processed. inserts are refused with status full once the entry count
// exceeds 8/10 of TABLE_SLOTS; there is no rehash
module robin_hood_hash_table_core #(
  parameter int unsigned TABLE_SLOTS = rhh_pkg::TableSlotsDef,
  parameter int unsigned KEY_WIDTH   = rhh_pkg::KeyWidthDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  rhh_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output rhh_pkg::rsp_t out_data_o
);

  // decoded request queue between front and back
  logic          cmd_valid, cmd_ready;
  rhh_pkg::cmd_t cmd;

  rhh_front #(
    .KEY_WIDTH(KEY_WIDTH)
  ) u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .in_data_i,
    .cmd_valid_o(cmd_valid),
    .cmd_ready_i(cmd_ready),
    .cmd_o      (cmd)
  );

  // probe sequencer, slot memories and result register
  rhh_back #(
    .TABLE_SLOTS(TABLE_SLOTS),
    .KEY_WIDTH  (KEY_WIDTH)
  ) u_back (
    .clk_i,
    .rst_ni,
    .cmd_valid_i(cmd_valid),
    .cmd_ready_o(cmd_ready),
    .cmd_i      (cmd),
    .out_valid_o,
    .out_ready_i,
    .out_data_o
  );

endmodule

[design/rhh_front.sv]
// rhh_front: accepts request beats, decodes and masks them, and queues them
// depends on rhh_pkg
module rhh_front #(
  parameter int unsigned KEY_WIDTH = rhh_pkg::KeyWidthDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  rhh_pkg::req_t in_data_i,
  output logic          cmd_valid_o,
  input  logic          cmd_ready_i,
  output rhh_pkg::cmd_t cmd_o
);

  localparam int unsigned KW = rhh_pkg::KeyMaxW;

  rhh_pkg::cmd_t fifo_q [2];
  logic          wptr_q, rptr_q;
  logic [1:0]    cnt_q;
  rhh_pkg::cmd_t dec;
  logic [KW-1:0] key_ext, key_mask;
  logic          push, pop;

  assign key_ext  = {{(KW-32){1'b0}}, in_data_i.key};
  assign key_mask = {KW{1'b1}} >> (KW - KEY_WIDTH);

  always_comb begin
    dec.op   = in_data_i.req_type ? rhh_pkg::OP_FIND : rhh_pkg::OP_INSERT;
    dec.key  = key_ext & key_mask;
    dec.hash = in_data_i.hash_value;
  end

  assign in_ready_o  = (cnt_q != 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = fifo_q[rptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) begin
        fifo_q[wptr_q] <= dec;
        wptr_q         <= ~wptr_q;
      end
      if (pop) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

[design/rhh_back.sv]
// rhh_back: probe sequencer over the slot memories, with clearing pass and result register
// depends on rhh_pkg
module rhh_back #(
  parameter int unsigned TABLE_SLOTS = rhh_pkg::TableSlotsDef,
  parameter int unsigned KEY_WIDTH   = rhh_pkg::KeyWidthDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  output logic          cmd_ready_o,
  input  rhh_pkg::cmd_t cmd_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output rhh_pkg::rsp_t out_data_o
);

  localparam int unsigned IW = $clog2(TABLE_SLOTS);
  localparam int unsigned CW = IW + 1;
  localparam int unsigned HW = rhh_pkg::HashW;
  localparam logic [CW-1:0] LoadMax =
    CW'((rhh_pkg::LoadNum * TABLE_SLOTS) / rhh_pkg::LoadDen);
  localparam logic [IW:0] SlotsN = (IW+1)'(TABLE_SLOTS);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_READ, S_EVAL} state_e;

  state_e               state_q;
  logic [IW-1:0]        clr_q, idx_q, land_q;
  logic [IW:0]          dist_q, n_q;
  logic [KEY_WIDTH-1:0] car_key_q, rd_k_q;
  logic [HW-1:0]        car_hash_q;
  rhh_pkg::op_e         op_q;
  logic                 placed_q;
  logic [CW-1:0]        cnt_q;
  logic                 rsp_valid_q;
  rhh_pkg::rsp_t        rsp_q;
  logic [HW:0]          rd_h_q;

  logic [HW:0]          hmem [TABLE_SLOTS];
  logic [KEY_WIDTH-1:0] kmem [TABLE_SLOTS];

  logic                 h_we, k_we;
  logic [IW-1:0]        h_wa;
  logic [HW:0]          h_wd;
  logic [IW-1:0]        res_dist;
  logic                 res_valid, hit, farther;
  logic [IW+9:0]        idx_ext, land_ext;

  assign res_valid = rd_h_q[HW];
  assign res_dist  = idx_q - rd_h_q[IW-1:0];
  assign hit       = (rd_h_q[HW-1:0] == car_hash_q) && (rd_k_q == car_key_q);
  assign farther   = dist_q > {1'b0, res_dist};
  assign idx_ext   = {10'd0, idx_q};
  assign land_ext  = {10'd0, land_q};

  assign cmd_ready_o = (state_q == S_IDLE) && !rsp_valid_q;
  assign out_valid_o = rsp_valid_q;
  assign out_data_o  = rsp_q;

  // memory writes: clearing pass, landing in an empty slot, or a swap
  always_comb begin
    h_we = 1'b0;
    k_we = 1'b0;
    h_wa = idx_q;
    h_wd = {1'b1, car_hash_q};
    if (state_q == S_CLEAR) begin
      h_we = 1'b1;
      h_wa = clr_q;
      h_wd = '0;
    end else if (state_q == S_EVAL && op_q == rhh_pkg::OP_INSERT) begin
      if (!res_valid || (!hit && farther)) begin
        h_we = 1'b1;
        k_we = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (h_we) hmem[h_wa] <= h_wd;
    if (k_we) kmem[idx_q] <= car_key_q;
    rd_h_q <= hmem[idx_q];
    rd_k_q <= kmem[idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      idx_q       <= '0;
      land_q      <= '0;
      dist_q      <= '0;
      n_q         <= '0;
      car_key_q   <= '0;
      car_hash_q  <= '0;
      op_q        <= rhh_pkg::OP_INSERT;
      placed_q    <= 1'b0;
      cnt_q       <= '0;
      rsp_valid_q <= 1'b0;
      rsp_q       <= '0;
    end else begin
      if (rsp_valid_q && out_ready_i) rsp_valid_q <= 1'b0;
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == {IW{1'b1}}) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (cmd_valid_i && cmd_ready_o) begin
            op_q       <= cmd_i.op;
            car_key_q  <= cmd_i.key[KEY_WIDTH-1:0];
            car_hash_q <= cmd_i.hash;
            idx_q      <= cmd_i.hash[IW-1:0];
            dist_q     <= '0;
            n_q        <= '0;
            placed_q   <= 1'b0;
            if (cmd_i.op == rhh_pkg::OP_INSERT && cnt_q > LoadMax) begin
              rsp_valid_q <= 1'b1;
              rsp_q       <= '{status: rhh_pkg::ST_FULL, slot_index: '0};
            end else begin
              state_q <= S_READ;
            end
          end
        end
        S_READ: state_q <= S_EVAL;
        S_EVAL: begin
          state_q <= S_READ;
          idx_q   <= idx_q + 1'b1;
          dist_q  <= dist_q + 1'b1;
          n_q     <= n_q + 1'b1;
          if (op_q == rhh_pkg::OP_FIND) begin
            if (!res_valid || farther) begin
              state_q     <= S_IDLE;
              rsp_valid_q <= 1'b1;
              rsp_q       <= '{status: rhh_pkg::ST_MISSING, slot_index: '0};
            end else if (hit) begin
              state_q     <= S_IDLE;
              rsp_valid_q <= 1'b1;
              rsp_q       <= '{status: rhh_pkg::ST_FOUND, slot_index: idx_ext[9:0]};
            end
          end else begin
            if (!res_valid) begin
              state_q     <= S_IDLE;
              cnt_q       <= cnt_q + 1'b1;
              rsp_valid_q <= 1'b1;
              rsp_q       <= '{status: rhh_pkg::ST_INSERTED,
                               slot_index: placed_q ? land_ext[9:0] : idx_ext[9:0]};
            end else if (hit) begin
              state_q     <= S_IDLE;
              rsp_valid_q <= 1'b1;
              rsp_q       <= '{status: rhh_pkg::ST_PRESENT, slot_index: idx_ext[9:0]};
            end else begin
              if (farther) begin
                // resident is richer: take its slot and carry it onward
                car_key_q  <= rd_k_q;
                car_hash_q <= rd_h_q[HW-1:0];
                dist_q     <= {1'b0, res_dist} + 1'b1;
                if (!placed_q) begin
                  placed_q <= 1'b1;
                  land_q   <= idx_q;
                end
              end
              if (n_q + 1'b1 == SlotsN) begin
                state_q     <= S_IDLE;
                rsp_valid_q <= 1'b1;
                rsp_q       <= '{status: rhh_pkg::ST_FULL, slot_index: '0};
              end
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

[design/rhh_checker.sv]
// rhh_checker: port-level assertions for robin_hood_hash_table_core, and their bind
// depends on rhh_pkg
module rhh_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input rhh_pkg::req_t in_data_i,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input rhh_pkg::rsp_t out_data_o
);

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_data_i))
    else $error("request beat withdrawn or changed while waiting");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("result payload changed while stalled");

  a_status_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.status <= rhh_pkg::ST_FULL)
    else $error("illegal status code");

  a_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == rhh_pkg::ST_MISSING ||
                    out_data_o.status == rhh_pkg::ST_FULL)
    |-> out_data_o.slot_index == 10'd0)
    else $error("slot index not zero on miss or full");

endmodule

bind robin_hood_hash_table_core rhh_checker u_rhh_checker (.*);
